### src/fmrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmrq_pkg
// Shared codes, request record and header byte layout of the message ring.
// ----------------------------------------------------------------------------
package fmrq_pkg;

   localparam logic [1:0] OP_PUSH_START = 2'd0;
   localparam logic [1:0] OP_PUSH_BYTE  = 2'd1;
   localparam logic [1:0] OP_POP_START  = 2'd2;
   localparam logic [1:0] OP_POP_BYTE   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_TOO_SMALL = 3'd3;
   localparam logic [2:0] ST_OOS       = 3'd4;

   // header offsets fit in six bits (header is at most 64 bytes)
   localparam int HDR_IDX_W = 6;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] msg_length;
      logic [63:0] info_word;
      logic [31:0] stamp;
      logic [7:0]  data_byte;
      logic [11:0] max_len;
      logic        no_limit;
   } cmd_type;

   // header: 4 zero bytes, length, stamp, info (all little endian), then zeros
   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] k,
                                           input logic [11:0] len,
                                           input logic [31:0] stamp,
                                           input logic [63:0] info);
      logic [31:0]          l32;
      logic [HDR_IDX_W-1:0] ik;
      logic [7:0]           b;
      l32 = {20'd0, len};
      ik  = k - HDR_IDX_W'(12);
      b   = 8'd0;
      if (k >= HDR_IDX_W'(4) && k < HDR_IDX_W'(8)) begin
         b = 8'(l32 >> {k[1:0], 3'b000});
      end else if (k >= HDR_IDX_W'(8) && k < HDR_IDX_W'(12)) begin
         b = 8'(stamp >> {k[1:0], 3'b000});
      end else if (k >= HDR_IDX_W'(12) && k < HDR_IDX_W'(20)) begin
         b = 8'(info >> {ik[2:0], 3'b000});
      end
      return b;
   endfunction

endpackage

### src/fmrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmrq_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
module fmrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### src/fmrq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmrq_front
// Request intake: decodes each request into a command and queues two deep.
// ----------------------------------------------------------------------------
module fmrq_front import fmrq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_msg_length,
   input  logic [63:0] req_info_word,
   input  logic [31:0] req_stamp,
   input  logic [7:0]  req_data_byte,
   input  logic [11:0] req_max_len,
   input  logic        req_no_limit,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output logic        empty
);

   cmd_type     ent_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     new_cmd;
   logic        push;

   always_comb begin
      new_cmd            = '0;
      new_cmd.op         = req_op;
      case (req_op)
         OP_PUSH_START: begin
            new_cmd.msg_length = req_msg_length;
            new_cmd.info_word  = req_info_word;
            new_cmd.stamp      = req_stamp;
         end
         OP_PUSH_BYTE: begin
            new_cmd.data_byte = req_data_byte;
         end
         OP_POP_START: begin
            new_cmd.max_len  = req_max_len;
            new_cmd.no_limit = req_no_limit;
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd       = ent_ff[rd_ff];
   assign cmd_valid = (cnt_ff != 2'd0);
   assign empty     = (cnt_ff == 2'd0);

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = cmd_take ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

### src/fmrq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmrq_back
// Ring engine: pointers, header write and read walks, payload bytes, result.
// ----------------------------------------------------------------------------
module fmrq_back import fmrq_pkg::*; #(
   parameter int RING_BYTES   = 4096,
   parameter int HEADER_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,
   output logic        idle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_out_length,
   output logic [63:0] rsp_out_info,
   output logic [31:0] rsp_out_stamp,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   localparam int AW = $clog2(RING_BYTES);
   localparam int CW = AW + 1;
   localparam int KW = $clog2(HEADER_BYTES);
   localparam int SW = ((CW > 13) ? CW : 13) + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HWR   = 3'd1;
   localparam logic [2:0] S_HRD   = 3'd2;
   localparam logic [2:0] S_HLAST = 3'd3;
   localparam logic [2:0] S_HCHK  = 3'd4;
   localparam logic [2:0] S_PWAIT = 3'd5;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_PUSH = 2'd1;
   localparam logic [1:0] MODE_POP  = 2'd2;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW-1:0] pwp_ff, pwp_in, prp_ff, prp_in;
   logic [AW-1:0] p_ff, p_in;
   logic [11:0]   rem_ff, rem_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] rd_k_ff, rd_k_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          lastb_ff, lastb_in;
   logic [31:0]   len_ff, len_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [63:0]   info_ff, info_in;
   logic [11:0]   max_ff, max_in;
   logic          nolim_ff, nolim_in;
   logic [CW-1:0] used_ff, used_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic [11:0]   olen_ff, olen_in;
   logic [63:0]   oinfo_ff, oinfo_in;
   logic [31:0]   ostamp_ff, ostamp_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic          last_ff, last_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic [CW:0]   diff;
   logic [CW-1:0] used;
   logic [CW-1:0] free_b;
   logic          full;
   logic          out_free;
   logic [31:0]   csr_wide;

   fmrq_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      return (n >= cap_ff) ? AW'(0) : n[AW-1:0];
   endfunction

   always_comb begin
      diff   = {2'b00, wp_ff} + {1'b0, cap_ff} - {2'b00, rp_ff};
      used   = (diff >= {1'b0, cap_ff}) ? CW'(diff - {1'b0, cap_ff}) : CW'(diff);
      free_b = cap_ff - used;
      full   = SW'(free_b) <= (SW'(cmd.msg_length) + SW'(HEADER_BYTES));
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idle     = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_wide = 32'(csr_wdata);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cap_in       = cap_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      pwp_in       = pwp_ff;
      prp_in       = prp_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      rd_k_in      = k_ff;
      rd_vld_in    = 1'b0;
      lastb_in     = lastb_ff;
      len_in       = len_ff;
      stamp_in     = stamp_ff;
      info_in      = info_ff;
      max_in       = max_ff;
      nolim_in     = nolim_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      olen_in      = olen_ff;
      oinfo_in     = oinfo_ff;
      ostamp_in    = ostamp_ff;
      obyte_in     = obyte_ff;
      last_in      = last_ff;
      ram_we       = 1'b0;
      ram_addr     = p_ff;
      ram_wdata    = 8'd0;
      cmd_take     = 1'b0;

      if (rd_vld_ff) begin
         for (int i = 0; i < 4; i++) begin
            if (rd_k_ff == KW'(i + 4)) len_in[8*i +: 8] = ram_rdata;
            if (rd_k_ff == KW'(i + 8)) stamp_in[8*i +: 8] = ram_rdata;
         end
         for (int i = 0; i < 8; i++) begin
            if ((i + 12 < HEADER_BYTES) && (rd_k_ff == KW'(i + 12))) begin
               info_in[8*i +: 8] = ram_rdata;
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               if (csr_wide == 32'd0) begin
                  cap_in = CW'(1);
               end else if (csr_wide > 32'(RING_BYTES)) begin
                  cap_in = CW'(RING_BYTES);
               end else begin
                  cap_in = CW'(csr_wdata);
               end
               wp_in   = '0;
               rp_in   = '0;
               pwp_in  = '0;
               prp_in  = '0;
               rem_in  = '0;
               mode_in = MODE_IDLE;
            end else if (cmd_valid && out_free) begin
               cmd_take  = 1'b1;
               status_in = ST_OK;
               olen_in   = '0;
               oinfo_in  = '0;
               ostamp_in = '0;
               obyte_in  = '0;
               last_in   = 1'b0;
               case (cmd.op)
                  OP_PUSH_START: begin
                     mode_in = MODE_IDLE;
                     if (full) begin
                        status_in    = ST_FULL;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_HWR;
                        k_in     = '0;
                        p_in     = wp_ff;
                        len_in   = {20'd0, cmd.msg_length};
                        stamp_in = cmd.stamp;
                        info_in  = cmd.info_word;
                     end
                  end
                  OP_PUSH_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (mode_ff != MODE_PUSH) begin
                        status_in = ST_OOS;
                     end else begin
                        ram_we    = 1'b1;
                        ram_addr  = pwp_ff;
                        ram_wdata = cmd.data_byte;
                        pwp_in    = step_ptr(pwp_ff);
                        rem_in    = rem_ff - 12'd1;
                        if (rem_ff == 12'd1) begin
                           wp_in   = step_ptr(pwp_ff);
                           mode_in = MODE_IDLE;
                           last_in = 1'b1;
                        end
                     end
                  end
                  OP_POP_START: begin
                     mode_in = MODE_IDLE;
                     if (32'(used) < 32'(HEADER_BYTES)) begin
                        status_in    = ST_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_HRD;
                        k_in     = '0;
                        p_in     = rp_ff;
                        used_in  = used;
                        max_in   = cmd.max_len;
                        nolim_in = cmd.no_limit;
                        len_in   = '0;
                        stamp_in = '0;
                        info_in  = '0;
                     end
                  end
                  default: begin
                     if (mode_ff != MODE_POP) begin
                        status_in    = ST_OOS;
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_addr = prp_ff;
                        prp_in   = step_ptr(prp_ff);
                        rem_in   = rem_ff - 12'd1;
                        lastb_in = (rem_ff == 12'd1);
                        if (rem_ff == 12'd1) begin
                           rp_in   = step_ptr(prp_ff);
                           mode_in = MODE_IDLE;
                        end
                        state_in = S_PWAIT;
                     end
                  end
               endcase
            end
         end
         S_HWR: begin
            ram_we    = 1'b1;
            ram_addr  = p_ff;
            ram_wdata = hdr_byte(HDR_IDX_W'(k_ff), len_ff[11:0], stamp_ff, info_ff);
            p_in      = step_ptr(p_ff);
            k_in      = k_ff + KW'(1);
            if (k_ff == KW'(HEADER_BYTES - 1)) begin
               state_in     = S_IDLE;
               pwp_in       = step_ptr(p_ff);
               rem_in       = len_ff[11:0];
               rsp_valid_in = 1'b1;
               if (len_ff[11:0] == 12'd0) begin
                  wp_in   = step_ptr(p_ff);
                  last_in = 1'b1;
               end else begin
                  mode_in = MODE_PUSH;
               end
            end
         end
         S_HRD: begin
            ram_addr  = p_ff;
            rd_vld_in = 1'b1;
            rd_k_in   = k_ff;
            p_in      = step_ptr(p_ff);
            k_in      = k_ff + KW'(1);
            if (k_ff == KW'(HEADER_BYTES - 1)) begin
               state_in = S_HLAST;
            end
         end
         S_HLAST: begin
            state_in = S_HCHK;
         end
         S_HCHK: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!nolim_ff && (32'(max_ff) < len_ff)) begin
               status_in = ST_TOO_SMALL;
               olen_in   = len_ff[11:0];
            end else if ((32'(used_ff) - 32'(HEADER_BYTES)) < len_ff) begin
               status_in = ST_EMPTY;
            end else begin
               olen_in   = len_ff[11:0];
               oinfo_in  = info_ff;
               ostamp_in = stamp_ff;
               prp_in    = p_ff;
               rem_in    = len_ff[11:0];
               if (len_ff == 32'd0) begin
                  rp_in   = p_ff;
                  last_in = 1'b1;
               end else begin
                  mode_in = MODE_POP;
               end
            end
         end
         S_PWAIT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            obyte_in     = ram_rdata;
            last_in      = lastb_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_IDLE;
         cap_ff       <= CW'(RING_BYTES);
         wp_ff        <= '0;
         rp_ff        <= '0;
         pwp_ff       <= '0;
         prp_ff       <= '0;
         rem_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         pwp_ff       <= pwp_in;
         prp_ff       <= prp_in;
         rem_ff       <= rem_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff      <= p_in;
      k_ff      <= k_in;
      rd_k_ff   <= rd_k_in;
      lastb_ff  <= lastb_in;
      len_ff    <= len_in;
      stamp_ff  <= stamp_in;
      info_ff   <= info_in;
      max_ff    <= max_in;
      nolim_ff  <= nolim_in;
      used_ff   <= used_in;
      status_ff <= status_in;
      olen_ff   <= olen_in;
      oinfo_ff  <= oinfo_in;
      ostamp_ff <= ostamp_in;
      obyte_ff  <= obyte_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_length = olen_ff;
   assign rsp_out_info   = oinfo_ff;
   assign rsp_out_stamp  = ostamp_ff;
   assign rsp_out_byte   = obyte_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result held while a walk is running");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(wp_ff) < cap_ff) && (CW'(rp_ff) < cap_ff))
      else $error("committed pointer beyond capacity");

   a_mode_rem: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (rem_ff != 12'd0))
      else $error("transfer open with no bytes left");

   a_check_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HCHK) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("header check did not produce a result");
`endif

endmodule

### src/framed_message_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_message_ring_queue
// Byte ring holding framed messages: header (length, stamp, info) + payload.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  op, length, info, stamp, byte, limit
//  rsp_      out        rsp_valid/rsp_stall  status, length, info, stamp, byte, last
//  csr_      in         csr_valid/csr_ready  ring capacity (13 bits)
//
//  Payload requests are handled from the engine's idle state (pop byte adds one RAM read).
//  Push and pop start walk the header through the single RAM port, one byte
//  a cycle; pop then passes S_HLAST and S_HCHK before its result is set.
//  A two-deep request queue decouples intake from the engine; rsp is a register.
//  Reset is synchronous; the ring contents are not cleared, only pointers and control state.
// ----------------------------------------------------------------------------
module framed_message_ring_queue import fmrq_pkg::*; #(
   parameter int RING_BYTES   = 4096,
   parameter int HEADER_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_msg_length,
   input  logic [63:0] req_info_word,
   input  logic [31:0] req_stamp,
   input  logic [7:0]  req_data_byte,
   input  logic [11:0] req_max_len,
   input  logic        req_no_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_out_length,
   output logic [63:0] rsp_out_info,
   output logic [31:0] rsp_out_stamp,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_wdata
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;
   logic    front_empty;
   logic    back_idle;

   fmrq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_msg_length (req_msg_length),
      .req_info_word  (req_info_word),
      .req_stamp      (req_stamp),
      .req_data_byte  (req_data_byte),
      .req_max_len    (req_max_len),
      .req_no_limit   (req_no_limit),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .empty          (front_empty)
   );

   assign csr_ready = front_empty && back_idle;

   fmrq_back #(
      .RING_BYTES   (RING_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .csr_we         (csr_valid && csr_ready),
      .csr_wdata      (csr_wdata),
      .idle           (back_idle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_length (rsp_out_length),
      .rsp_out_info   (rsp_out_info),
      .rsp_out_stamp  (rsp_out_stamp),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for framed_message_ring_queue: a shadow ring model
// predicts one response per accepted request. Directed framing cases come
// first, then random push/pop message sequences over several ring
// capacities, with random idling on both channels, a quiet stretch and one
// long response hold-off that backs the request path up.
// ----------------------------------------------------------------------------
module tb;
   import fmrq_pkg::*;

   localparam int RING_MAX  = 4096;
   localparam int HDR_LEN   = 20;
   localparam int CYC_LIMIT = 400000;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] length;
      logic [63:0] info;
      logic [31:0] stamp;
      logic [7:0]  data;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {XFER_IDLE, XFER_PUSH, XFER_POP} xfer_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_PUSH_START;
   logic [11:0] req_msg_length = '0;
   logic [63:0] req_info_word = '0;
   logic [31:0] req_stamp = '0;
   logic [7:0]  req_data_byte = '0;
   logic [11:0] req_max_len = '0;
   logic        req_no_limit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_out_length;
   logic [63:0] rsp_out_info;
   logic [31:0] rsp_out_stamp;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_wdata = '0;

   framed_message_ring_queue dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow ring
   logic [7:0]    shadow_ring [RING_MAX];
   int            ring_cap;
   int            wr_ptr, rd_ptr, wr_pend, rd_pend, bytes_left;
   xfer_mode_type xfer_mode;

   cmd_type    request_q [$];
   rsp_type    expected_responses [$];
   int         gen_lens [$];
   cmd_type    cur_req;
   int         n_queued = 0;
   int         n_accepted = 0;
   int         n_errors = 0;
   int         cycles = 0;
   int         holdoff_left = 0;
   bit         holdoff_done = 1'b0;

   function automatic bit quiet_span();
      return n_accepted >= 150 && n_accepted < 260;
   endfunction

   function automatic int ring_next(int p);
      return (p + 1 >= ring_cap) ? 0 : p + 1;
   endfunction

   function automatic int ring_used();
      return (wr_ptr % ring_cap + ring_cap - rd_ptr % ring_cap) % ring_cap;
   endfunction

   task automatic set_capacity(logic [12:0] v);
      int c;
      c = v;
      if (c < 1) c = 1;
      if (c > RING_MAX) c = RING_MAX;
      ring_cap = c;
      wr_ptr = 0; rd_ptr = 0; wr_pend = 0; rd_pend = 0; bytes_left = 0;
      xfer_mode = XFER_IDLE;
   endtask

   task automatic ring_model_step(input cmd_type r, output rsp_type o);
      int           p, k, used, len;
      logic [31:0]  st;
      logic [63:0]  inf;
      logic [7:0]   b;
      logic [159:0] hdr;
      o = '0;
      case (r.op)
         OP_PUSH_START: begin
            xfer_mode = XFER_IDLE;
            if (ring_cap - ring_used() <= int'(r.msg_length) + HDR_LEN) begin
               o.status = ST_FULL;
            end else begin
               hdr = {r.info_word, r.stamp, 20'd0, r.msg_length, 32'd0};
               p = wr_ptr % ring_cap;
               for (k = 0; k < HDR_LEN; k++) begin
                  shadow_ring[p] = hdr[8*k +: 8];
                  p = ring_next(p);
               end
               wr_pend = p;
               bytes_left = r.msg_length;
               if (r.msg_length == 0) begin
                  wr_ptr = p;
                  o.last = 1'b1;
               end else begin
                  xfer_mode = XFER_PUSH;
               end
            end
         end
         OP_PUSH_BYTE: begin
            if (xfer_mode != XFER_PUSH) begin
               o.status = ST_OOS;
            end else begin
               shadow_ring[wr_pend] = r.data_byte;
               wr_pend = ring_next(wr_pend);
               bytes_left--;
               if (bytes_left == 0) begin
                  wr_ptr = wr_pend;
                  xfer_mode = XFER_IDLE;
                  o.last = 1'b1;
               end
            end
         end
         OP_POP_START: begin
            used = ring_used();
            xfer_mode = XFER_IDLE;
            if (used < HDR_LEN) begin
               o.status = ST_EMPTY;
            end else begin
               p = rd_ptr % ring_cap;
               for (k = 0; k < HDR_LEN; k++) begin
                  hdr[8*k +: 8] = shadow_ring[p];
                  p = ring_next(p);
               end
               len = hdr[63:32];
               st  = hdr[95:64];
               inf = hdr[159:96];
               if (!r.no_limit && int'(r.max_len) < len) begin
                  o.status = ST_TOO_SMALL;
                  o.length = len[11:0];
               end else if (used - HDR_LEN < len) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.length = len[11:0];
                  o.info = inf;
                  o.stamp = st;
                  rd_pend = p;
                  bytes_left = len;
                  if (len == 0) begin
                     rd_ptr = p;
                     o.last = 1'b1;
                  end else begin
                     xfer_mode = XFER_POP;
                  end
               end
            end
         end
         default: begin
            if (xfer_mode != XFER_POP) begin
               o.status = ST_OOS;
            end else begin
               b = shadow_ring[rd_pend];
               o.data = b;
               rd_pend = ring_next(rd_pend);
               bytes_left--;
               if (bytes_left == 0) begin
                  rd_ptr = rd_pend;
                  xfer_mode = XFER_IDLE;
                  o.last = 1'b1;
               end
            end
         end
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      rsp_type pred;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            ring_model_step(cur_req, pred);
            expected_responses.push_back(pred);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (request_q.size() > 0 && (quiet_span() || $urandom_range(99) >= 37)) begin
               cur_req = request_q.pop_front();
               req_op <= cur_req.op;
               req_msg_length <= cur_req.msg_length;
               req_info_word <= cur_req.info_word;
               req_stamp <= cur_req.stamp;
               req_data_byte <= cur_req.data_byte;
               req_max_len <= cur_req.max_len;
               req_no_limit <= cur_req.no_limit;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && n_accepted >= 400) begin
         holdoff_done <= 1'b1;
         holdoff_left <= 300;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response, status %0d", rsp_status);
            n_errors++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_status);
               n_errors++;
            end
            if (rsp_out_length !== want.length) begin
               $error("out_length exp %0d got %0d", want.length, rsp_out_length);
               n_errors++;
            end
            if (rsp_out_info !== want.info) begin
               $error("out_info exp %h got %h", want.info, rsp_out_info);
               n_errors++;
            end
            if (rsp_out_stamp !== want.stamp) begin
               $error("out_stamp exp %h got %h", want.stamp, rsp_out_stamp);
               n_errors++;
            end
            if (rsp_out_byte !== want.data) begin
               $error("out_byte exp %h got %h", want.data, rsp_out_byte);
               n_errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last exp %0d got %0d", want.last, rsp_last);
               n_errors++;
            end
         end
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_span() && $urandom_range(99) < 37;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus
   function automatic cmd_type rand_cmd(logic [1:0] op);
      cmd_type c;
      c.op = op;
      c.msg_length = 12'($urandom);
      c.info_word = {$urandom, $urandom};
      c.stamp = $urandom;
      c.data_byte = 8'($urandom);
      c.max_len = 12'($urandom);
      c.no_limit = 1'($urandom);
      return c;
   endfunction

   task automatic add_req(cmd_type c);
      request_q.push_back(c);
      n_queued++;
   endtask

   task automatic add_push(int len, int nbytes);
      cmd_type c;
      c = rand_cmd(OP_PUSH_START);
      c.msg_length = 12'(len);
      add_req(c);
      repeat (nbytes) add_req(rand_cmd(OP_PUSH_BYTE));
   endtask

   task automatic add_pop(logic [11:0] max_len, logic no_limit, int nbytes);
      cmd_type c;
      c = rand_cmd(OP_POP_START);
      c.max_len = max_len;
      c.no_limit = no_limit;
      add_req(c);
      repeat (nbytes) add_req(rand_cmd(OP_POP_BYTE));
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (n_accepted != n_queued || expected_responses.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [12:0] v);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      set_capacity(v);
      csr_valid <= 1'b0;
   endtask

   task automatic random_messages(int n_items, int len_hi);
      int      r, len, target;
      cmd_type c;
      target = n_queued + n_items;
      gen_lens.delete();
      while (n_queued < target) begin
         r = $urandom_range(99);
         if (r < 40) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(len_hi * 4)
                                           : $urandom_range(len_hi);
            add_push(len, len);
            gen_lens.push_back(len);
         end else if (r < 80) begin
            len = (gen_lens.size() > 0) ? gen_lens.pop_front() : $urandom_range(3);
            if ($urandom_range(7) == 0) begin
               add_pop(12'($urandom_range(len_hi)), 1'b0, len);
            end else begin
               add_pop($urandom_range(1) ? 12'hFFF : 12'(len), 1'($urandom), len);
            end
         end else if (r < 90) begin
            add_req(rand_cmd(2'($urandom)));
         end else begin
            len = $urandom_range(1, len_hi + 1);
            add_push(len, $urandom_range(len - 1));
            if (gen_lens.size() > 0) begin
               c = rand_cmd(OP_POP_START);
               c.no_limit = 1'b1;
               add_req(c);
               repeat ($urandom_range(gen_lens[0])) add_req(rand_cmd(OP_POP_BYTE));
            end
         end
      end
   endtask

   initial begin
      cmd_type c;
      set_capacity(13'd4096);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty ring, payload requests out of sequence, refused full push
      add_pop(12'hFFF, 1'b1, 0);
      add_req(rand_cmd(OP_PUSH_BYTE));
      add_req(rand_cmd(OP_POP_BYTE));
      add_push(4095, 0);
      c = rand_cmd(OP_PUSH_START);
      c.msg_length = '0;
      c.info_word = '1;
      c.stamp = '1;
      add_req(c);
      c = rand_cmd(OP_PUSH_START);
      c.msg_length = 12'd3;
      c.info_word = '0;
      c.stamp = '0;
      add_req(c);
      c = rand_cmd(OP_PUSH_BYTE);
      c.data_byte = 8'h00;
      add_req(c);
      c.data_byte = 8'hFF;
      add_req(c);
      add_req(rand_cmd(OP_PUSH_BYTE));
      // abandoned push, then a one byte message
      add_push(5, 2);
      add_push(1, 1);
      add_pop(12'd0, 1'b0, 0);
      add_pop(12'd2, 1'b0, 0);
      add_pop(12'hFFF, 1'b0, 3);
      add_pop(12'd0, 1'b1, 1);
      // abandoned pop restarts from the committed read pointer
      add_push(2, 2);
      add_pop(12'd2, 1'b0, 1);
      add_pop(12'd2, 1'b0, 2);
      add_pop(12'd0, 1'b0, 0);

      random_messages(260, 10);

      write_capacity(13'd22);
      add_push(1, 1);
      add_push(0, 0);
      add_pop(12'hFFF, 1'b1, 1);
      random_messages(60, 1);

      write_capacity(13'h1FFF);
      random_messages(160, 12);

      write_capacity(13'd0);
      add_push(0, 0);
      add_pop(12'hFFF, 1'b1, 0);
      add_req(rand_cmd(OP_POP_BYTE));

      write_capacity(13'd21);
      add_push(0, 0);
      add_pop(12'hFFF, 1'b1, 0);

      write_capacity(13'd57);
      random_messages(100, 8);

      write_capacity(13'd1000);
      random_messages(120, 30);

      drain();
      repeat (40) @(posedge clock);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
src/fmrq_pkg.sv
src/fmrq_ram.sv
src/fmrq_front.sv
src/fmrq_back.sv
src/framed_message_ring_queue.sv
dv/tb.sv
